FILE: hdl/crr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and constants of the A1 cell reference parser: character
// classes, status codes, field widths and the item and result records.
// ----------------------------------------------------------------------------
package crr_pkg;

  localparam int unsigned RowW   = 20;
  localparam int unsigned ColW   = 14;
  localparam int unsigned CountW = 35;
  localparam int unsigned RowAccW = RowW + 1;
  localparam int unsigned ColAccW = ColW + 1;

  localparam logic [7:0] ChrA     = 8'h41;
  localparam logic [7:0] ChrZ     = 8'h5a;
  localparam logic [7:0] Chr0     = 8'h30;
  localparam logic [7:0] Chr9     = 8'h39;
  localparam logic [7:0] ChrColon = 8'h3a;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StSyntax = 2'd1;
  localparam logic [1:0] StRange  = 2'd2;

  typedef enum logic [1:0] {
    ClsLetter = 2'd0,
    ClsDigit  = 2'd1,
    ClsColon  = 2'd2,
    ClsOther  = 2'd3
  } crr_class_e;

  typedef struct packed {
    crr_class_e cls;
    logic [4:0] val;
    logic       last;
  } crr_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            range_mode;
    logic [RowW-1:0] row_a;
    logic [ColW-1:0] col_a;
    logic [RowW-1:0] row_b;
    logic [ColW-1:0] col_b;
  } crr_pre_t;

endpackage
`default_nettype wire

FILE: hdl/crr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crr channel interfaces
// Valid/ready channels for characters in, parse results out and the mode
// register write.
// ----------------------------------------------------------------------------
interface crr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface crr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] first_row;
  logic [13:0] first_column;
  logic [19:0] second_row;
  logic [13:0] second_column;
  logic [34:0] cell_count;

  modport source (output valid, output status, output first_row, output first_column,
                  output second_row, output second_column, output cell_count,
                  input ready);
  modport sink   (input valid, input status, input first_row, input first_column,
                  input second_row, input second_column, input cell_count,
                  output ready);
endinterface

interface crr_cfg_if;
  logic valid;
  logic ready;
  logic expect_range;

  modport source (output valid, output expect_range, input ready);
  modport sink   (input valid, input expect_range, output ready);
endinterface
`default_nettype wire

FILE: hdl/cell_range_reference_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cell_range_reference_parser
// A1-style cell reference parser, one character per transfer, result on the
// character flagged last.
// ----------------------------------------------------------------------------
// Takes one character every clock cycle with no gaps between references while
// the result side does not stall; the rate is set by the back part, which
// updates the column and row accumulators (a shift-add times 26 or 10 with
// saturation) once per character. The result of a reference passes from its
// last character through the front register, the queue with the back part
// after it, the corner ordering stage and the span multiplier into the output
// register. The front and back are separated by a two-entry queue, and the
// result side has its own output register, so a stalled result does not stop
// characters from being taken until the stages behind it fill.
// The mode register is written through cfg_i and is read by the back part at
// a colon and at the last character.
// ----------------------------------------------------------------------------
module cell_range_reference_parser #(
  parameter int unsigned MAX_ROWS    = 1048576,
  parameter int unsigned MAX_COLUMNS = 16384
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  crr_cfg_if.sink   cfg_i,
  crr_in_if.sink    in_i,
  crr_out_if.source out_o
);
  import crr_pkg::*;

  logic      expect_range_q;
  logic      fr_valid;
  crr_item_t fr_item;
  logic      fr_ready;
  logic      q_valid;
  crr_item_t q_item;
  logic      q_ready;
  logic      pre_valid;
  crr_pre_t  pre;
  logic      pre_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_range_q <= 1'b1;
    end else if (cfg_i.valid) begin
      expect_range_q <= cfg_i.expect_range;
    end
  end

  crr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .item_ready_i (fr_ready)
  );

  crr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_item_i  (fr_item),
    .push_ready_o (fr_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_ready_i  (q_ready)
  );

  crr_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .expect_range_i (expect_range_q),
    .item_valid_i   (q_valid),
    .item_i         (q_item),
    .item_ready_o   (q_ready),
    .res_valid_o    (pre_valid),
    .res_o          (pre),
    .res_ready_i    (pre_ready)
  );

  crr_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (pre_valid),
    .res_i       (pre),
    .res_ready_o (pre_ready),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

FILE: hdl/crr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crr_front
// Accepts characters and classifies them into letter, digit, colon or other,
// with the letter or digit value, into one register stage.
// ----------------------------------------------------------------------------
module crr_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  crr_in_if.sink             in_i,
  output logic               item_valid_o,
  output crr_pkg::crr_item_t item_o,
  input  wire                item_ready_i
);
  import crr_pkg::*;

  logic      valid_q;
  crr_item_t item_q;
  crr_item_t item_d;
  logic      take;

  assign in_i.ready = !valid_q || item_ready_i;
  assign take = in_i.valid && in_i.ready;

  always_comb begin
    item_d.last = in_i.is_last;
    item_d.val  = '0;
    if (in_i.char_code inside {[ChrA:ChrZ]}) begin
      item_d.cls = ClsLetter;
      item_d.val = 5'(in_i.char_code - ChrA + 8'd1);
    end else if (in_i.char_code inside {[Chr0:Chr9]}) begin
      item_d.cls = ClsDigit;
      item_d.val = 5'(in_i.char_code - Chr0);
    end else if (in_i.char_code == ChrColon) begin
      item_d.cls = ClsColon;
    end else begin
      item_d.cls = ClsOther;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

FILE: hdl/crr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crr_queue
// Two-entry queue of classified characters between front and back parts.
// ----------------------------------------------------------------------------
module crr_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_valid_i,
  input  crr_pkg::crr_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output crr_pkg::crr_item_t pop_item_o,
  input  wire                pop_ready_i
);
  import crr_pkg::*;

  crr_item_t  mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/crr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crr_back
// Parse sequencer: runs the letter/digit/colon phases, builds the saturating
// column and row accumulators and hands a raw result on the last character.
// ----------------------------------------------------------------------------
module crr_back #(
  parameter int unsigned MAX_ROWS    = 1048576,
  parameter int unsigned MAX_COLUMNS = 16384
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                expect_range_i,
  input  wire                item_valid_i,
  input  crr_pkg::crr_item_t item_i,
  output logic               item_ready_o,
  output logic               res_valid_o,
  output crr_pkg::crr_pre_t  res_o,
  input  wire                res_ready_i
);
  import crr_pkg::*;

  localparam logic [1:0] PhLet1 = 2'd0;
  localparam logic [1:0] PhDig1 = 2'd1;
  localparam logic [1:0] PhLet2 = 2'd2;
  localparam logic [1:0] PhDig2 = 2'd3;

  localparam logic [ColAccW-1:0] ColMax = ColAccW'(MAX_COLUMNS);
  localparam logic [RowAccW-1:0] RowMax = RowAccW'(MAX_ROWS);
  localparam logic [ColAccW-1:0] ColSat = ColAccW'(MAX_COLUMNS + 1);
  localparam logic [RowAccW-1:0] RowSat = RowAccW'(MAX_ROWS + 1);

  logic [1:0]         phase_q, phase_d;
  logic [ColAccW-1:0] col_q, col_d;
  logic [RowAccW-1:0] row_q, row_d;
  logic [RowW-1:0]    srow_q, srow_d;
  logic [ColW-1:0]    scol_q, scol_d;
  logic [1:0]         err_q, err_d;

  logic [19:0]        col_sum;
  logic [24:0]        row_sum;
  logic [ColAccW-1:0] col_add;
  logic [RowAccW-1:0] row_add;
  logic               step;
  logic [1:0]         err_fin;

  function automatic logic in_range(logic [RowAccW-1:0] r, logic [ColAccW-1:0] c);
    in_range = (r != '0) && (r <= RowMax) && (c != '0) && (c <= ColMax);
  endfunction

  assign item_ready_o = !item_i.last || res_ready_i;
  assign step        = item_valid_i && item_ready_o;
  assign res_valid_o = item_valid_i && item_i.last;

  // x26 and x10 as shift-adds, saturating at limit + 1
  always_comb begin
    col_sum = (20'(col_q) << 4) + (20'(col_q) << 3) + (20'(col_q) << 1) + 20'(item_i.val);
    row_sum = (25'(row_q) << 3) + (25'(row_q) << 1) + 25'(item_i.val);
    col_add = (col_sum > 20'(ColSat)) ? ColSat : ColAccW'(col_sum);
    row_add = (row_sum > 25'(RowSat)) ? RowSat : RowAccW'(row_sum);
  end

  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    srow_d  = srow_q;
    scol_d  = scol_q;
    err_d   = err_q;
    if (err_q != StSyntax) begin
      case (phase_q)
        PhLet1, PhLet2: begin
          if (item_i.cls == ClsLetter) begin
            col_d = col_add;
          end else if (item_i.cls == ClsDigit && col_q != '0) begin
            row_d   = row_add;
            phase_d = phase_q + 2'd1;
          end else begin
            err_d = StSyntax;
          end
        end
        PhDig1: begin
          if (item_i.cls == ClsDigit) begin
            row_d = row_add;
          end else if (item_i.cls == ClsColon && expect_range_i) begin
            if (!in_range(row_q, col_q) && err_q == StOk) begin
              err_d = StRange;
            end
            srow_d  = RowW'(row_q - RowAccW'(1));
            scol_d  = ColW'(col_q - ColAccW'(1));
            col_d   = '0;
            row_d   = '0;
            phase_d = PhLet2;
          end else begin
            err_d = StSyntax;
          end
        end
        PhDig2: begin
          if (item_i.cls == ClsDigit) begin
            row_d = row_add;
          end else begin
            err_d = StSyntax;
          end
        end
        default: err_d = StSyntax;
      endcase
    end

    err_fin = err_d;
    if (phase_d != (expect_range_i ? PhDig2 : PhDig1)) begin
      err_fin = StSyntax;
    end else if (!in_range(row_d, col_d) && err_d == StOk) begin
      err_fin = StRange;
    end

    res_o.status     = err_fin;
    res_o.range_mode = expect_range_i;
    res_o.row_a      = srow_d;
    res_o.col_a      = scol_d;
    res_o.row_b      = RowW'(row_d - RowAccW'(1));
    res_o.col_b      = ColW'(col_d - ColAccW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLet1;
      col_q   <= '0;
      row_q   <= '0;
      srow_q  <= '0;
      scol_q  <= '0;
      err_q   <= StOk;
    end else if (step) begin
      if (item_i.last) begin
        phase_q <= PhLet1;
        col_q   <= '0;
        row_q   <= '0;
        srow_q  <= '0;
        scol_q  <= '0;
        err_q   <= StOk;
      end else begin
        phase_q <= phase_d;
        col_q   <= col_d;
        row_q   <= row_d;
        srow_q  <= srow_d;
        scol_q  <= scol_d;
        err_q   <= err_d;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/crr_finish.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crr_finish
// Orders the two corners, forms the spans, multiplies them into the cell
// count and holds the result in the output register.
// ----------------------------------------------------------------------------
module crr_finish (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               res_valid_i,
  input  crr_pkg::crr_pre_t res_i,
  output logic              res_ready_o,
  crr_out_if.source         out_o
);
  import crr_pkg::*;

  logic               s1_valid_q;
  logic [1:0]         s1_status_q;
  logic [RowW-1:0]    s1_r0_q, s1_r1_q;
  logic [ColW-1:0]    s1_c0_q, s1_c1_q;
  logic [ColAccW-1:0] s1_cspan_q;
  logic [RowAccW-1:0] s1_rspan_q;

  logic [1:0]         s1_status_d;
  logic [RowW-1:0]    s1_r0_d, s1_r1_d;
  logic [ColW-1:0]    s1_c0_d, s1_c1_d;
  logic [ColAccW-1:0] s1_cspan_d;
  logic [RowAccW-1:0] s1_rspan_d;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [RowW-1:0]    out_r0_q, out_r1_q;
  logic [ColW-1:0]    out_c0_q, out_c1_q;
  logic [CountW-1:0]  out_count_q;

  logic               out_free;
  logic               s1_load;
  logic               out_load;
  logic [35:0]        product;

  assign out_free    = !out_valid_q || out_o.ready;
  assign res_ready_o = !s1_valid_q || out_free;
  assign s1_load     = res_valid_i && res_ready_o;
  assign out_load    = s1_valid_q && out_free;

  always_comb begin
    s1_status_d = res_i.status;
    s1_r1_d     = res_i.row_b;
    s1_c1_d     = res_i.col_b;
    s1_r0_d     = res_i.row_b;
    s1_c0_d     = res_i.col_b;
    if (res_i.range_mode) begin
      if (res_i.row_a > res_i.row_b) begin
        s1_r1_d = res_i.row_a;
      end else begin
        s1_r0_d = res_i.row_a;
      end
      if (res_i.col_a > res_i.col_b) begin
        s1_c1_d = res_i.col_a;
      end else begin
        s1_c0_d = res_i.col_a;
      end
    end
    if (res_i.status != StOk) begin
      s1_r0_d = '0;
      s1_r1_d = '0;
      s1_c0_d = '0;
      s1_c1_d = '0;
    end
    s1_cspan_d = ColAccW'(s1_c1_d) - ColAccW'(s1_c0_d) + ColAccW'(1);
    s1_rspan_d = RowAccW'(s1_r1_d) - RowAccW'(s1_r0_d) + RowAccW'(1);
    if (res_i.status != StOk) begin
      s1_cspan_d = '0;
      s1_rspan_d = '0;
    end
  end

  assign product = 36'(s1_cspan_q) * 36'(s1_rspan_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_status_q <= s1_status_d;
      s1_r0_q     <= s1_r0_d;
      s1_r1_q     <= s1_r1_d;
      s1_c0_q     <= s1_c0_d;
      s1_c1_q     <= s1_c1_d;
      s1_cspan_q  <= s1_cspan_d;
      s1_rspan_q  <= s1_rspan_d;
    end
    if (out_load) begin
      out_status_q <= s1_status_q;
      out_r0_q     <= s1_r0_q;
      out_r1_q     <= s1_r1_q;
      out_c0_q     <= s1_c0_q;
      out_c1_q     <= s1_c1_q;
      out_count_q  <= CountW'(product);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.first_row     = out_r0_q;
  assign out_o.first_column  = out_c0_q;
  assign out_o.second_row    = out_r1_q;
  assign out_o.second_column = out_c1_q;
  assign out_o.cell_count    = out_count_q;

endmodule
`default_nettype wire

FILE: hdl/crr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crr_checker
// Port-level checks of the parser results, bound to the top level.
// ----------------------------------------------------------------------------
module crr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  status,
  input wire [19:0] first_row,
  input wire [13:0] first_column,
  input wire [19:0] second_row,
  input wire [13:0] second_column,
  input wire [34:0] cell_count
);
  import crr_pkg::*;

  // result held until transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(cell_count) && $stable(status))
    else $error("result dropped or changed before transfer");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != StOk |-> cell_count == '0 && first_row == '0 &&
      first_column == '0 && second_row == '0 && second_column == '0)
    else $error("error result carries nonzero fields");

  a_ok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == StOk |-> first_row <= second_row &&
      first_column <= second_column && cell_count != '0)
    else $error("valid result with unordered corners or empty count");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status == StOk || status == StSyntax || status == StRange)
    else $error("unknown status code");

endmodule

bind cell_range_reference_parser crr_checker u_crr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .status        (out_o.status),
  .first_row     (out_o.first_row),
  .first_column  (out_o.first_column),
  .second_row    (out_o.second_row),
  .second_column (out_o.second_column),
  .cell_count    (out_o.cell_count)
);
`default_nettype wire
